// File: design/lcdps_pkg.sv
`timescale 1ns / 1ps
package lcdps_pkg;

  localparam int PANEL_WIDTH_DEF  = 96;
  localparam int PANEL_HEIGHT_DEF = 64;

  localparam int ADDR_W      = 13;
  localparam int ADDR_EXT_W  = 17;  // holds the largest panel size itself
  localparam int LEVEL_W     = 8;
  localparam int COLOR_W     = 16;
  localparam int PIX_W       = 8;
  localparam int CONTRAST_W  = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  localparam logic [LEVEL_W-1:0]    LEVEL_MAX     = 8'd128;
  localparam logic [CONTRAST_W-1:0] CONTRAST_HALF = 6'd32;
  localparam logic [CONTRAST_W-1:0] CONTRAST_RST  = 6'd32;
  localparam logic [COLOR_W-1:0]    BACK_RST      = 16'hFFFF;
  localparam logic [COLOR_W-1:0]    FORE_RST      = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CONTRAST   = 4'd0,
    CFG_BLANK      = 4'd1,
    CFG_BACK_RED   = 4'd2,
    CFG_BACK_GREEN = 4'd3,
    CFG_BACK_BLUE  = 4'd4,
    CFG_FORE_RED   = 4'd5,
    CFG_FORE_GREEN = 4'd6,
    CFG_FORE_BLUE  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } rgb16_t;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } rgb8_t;

  // Target level for one pixel from contrast, blanking and the pixel bit.
  function automatic logic [LEVEL_W-1:0] pick_target(input logic [CONTRAST_W-1:0] contrast,
                                                     input logic blank,
                                                     input logic pixel_on);
    logic [LEVEL_W-1:0] off_t;
    logic [LEVEL_W-1:0] on_t;
    if (blank) begin
      off_t = '0;
      on_t  = '0;
    end else if (contrast < CONTRAST_HALF) begin
      off_t = '0;
      on_t  = {contrast, 2'b00};
    end else begin
      off_t = {contrast - CONTRAST_HALF, 2'b00};
      on_t  = LEVEL_MAX;
    end
    return pixel_on ? on_t : off_t;
  endfunction

  // target + (old - target) * 3 / 4, quotient truncated toward zero.
  function automatic logic [LEVEL_W-1:0] next_level(input logic [LEVEL_W-1:0] old,
                                                    input logic [LEVEL_W-1:0] target);
    logic signed [10:0] diff;
    logic signed [10:0] prod;
    logic signed [10:0] quot;
    logic signed [10:0] sum;
    diff = $signed({3'b000, old}) - $signed({3'b000, target});
    prod = diff * 11'sd3;
    quot = prod[10] ? ((prod + 11'sd3) >>> 2) : (prod >>> 2);
    sum  = $signed({3'b000, target}) + quot;
    if (sum[10]) begin
      return '0;
    end else if (sum > $signed({3'b000, LEVEL_MAX})) begin
      return LEVEL_MAX;
    end
    return sum[LEVEL_W-1:0];
  endfunction

endpackage

// File: design/lcdps_level_store.sv
`timescale 1ns / 1ps
module lcdps_level_store #(
  parameter int DEPTH = lcdps_pkg::PANEL_WIDTH_DEF * lcdps_pkg::PANEL_HEIGHT_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [IDX_W-1:0]              rd_idx,
  output logic [lcdps_pkg::LEVEL_W-1:0] rd_data,
  input  logic                          wr_en,
  input  logic [IDX_W-1:0]              wr_idx,
  input  logic [lcdps_pkg::LEVEL_W-1:0] wr_data,
  output logic                          busy
);
  import lcdps_pkg::*;

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [LEVEL_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   clr_idx_r;
  logic [IDX_W-1:0]   clr_idx_nxt;
  logic               clearing_r;
  logic               clearing_nxt;

  // sweep every entry to zero once after reset
  always_comb begin
    clearing_nxt = clearing_r;
    clr_idx_nxt  = clr_idx_r;
    if (clearing_r) begin
      if (clr_idx_r == IDX_W'(DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end else begin
        clr_idx_nxt = clr_idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_idx_r  <= '0;
    end else begin
      clearing_r <= clearing_nxt;
      clr_idx_r  <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  assign rd_data = rd_data_r;
  assign busy    = clearing_r;

endmodule

// File: design/lcdps_blend.sv
`timescale 1ns / 1ps
module lcdps_blend (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lcdps_pkg::ADDR_W-1:0]  in_addr,
  input  logic [lcdps_pkg::LEVEL_W-1:0] in_level,
  input  lcdps_pkg::rgb16_t             back,
  input  lcdps_pkg::rgb16_t             fore,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [lcdps_pkg::ADDR_W-1:0]  out_addr,
  output logic [lcdps_pkg::LEVEL_W-1:0] out_level,
  output lcdps_pkg::rgb8_t              out_color
);
  import lcdps_pkg::*;

  // (back * (128 - level) + fore * level + 16384) >> 15, held at 255
  function automatic logic [PIX_W-1:0] blend_chan(input logic [COLOR_W-1:0] b,
                                                  input logic [COLOR_W-1:0] f,
                                                  input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] bw;
    logic [23:0]        pb;
    logic [23:0]        pf;
    logic [24:0]        sum;
    logic [9:0]         c;
    bw  = LEVEL_MAX - lvl;
    pb  = b * bw;
    pf  = f * lvl;
    sum = {1'b0, pb} + {1'b0, pf} + 25'd16384;
    c   = sum[24:15];
    return (c > 10'd255) ? {PIX_W{1'b1}} : c[PIX_W-1:0];
  endfunction

  logic               valid_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [LEVEL_W-1:0] level_r;
  rgb8_t              color_r;
  rgb8_t              color_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    color_nxt.red   = blend_chan(back.red,   fore.red,   in_level);
    color_nxt.green = blend_chan(back.green, fore.green, in_level);
    color_nxt.blue  = blend_chan(back.blue,  fore.blue,  in_level);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      addr_r  <= in_addr;
      level_r <= in_level;
      color_r <= color_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_addr  = addr_r;
  assign out_level = level_r;
  assign out_color = color_r;

endmodule

// File: design/lcd_persistence_shader.sv
`timescale 1ns / 1ps
// LCD persistence shader: each input beat is one monochrome panel pixel and its
// raster address; each output beat gives that pixel's new darkness level (0..128)
// and its screen color, blended per channel between the background and foreground
// colors. A per-pixel level store (PANEL_WIDTH * PANEL_HEIGHT entries, one
// synchronous RAM) pulls every level one quarter of the way toward a
// target picked by contrast, blanking and the pixel bit. The block takes one
// beat per clock unless stage 1 is held or the RAM is clearing; a beat passes
// through the stage 1, stage 2 and blend output registers to the output.
// The rate is set by the single read-modify-write pass through the level RAM:
// read on accept, update and write back as the beat leaves stage 1, with the
// fresh level forwarded when two beats in a row hit the same pixel. After reset
// the RAM is swept to zero, one entry after another, and in_tready stays low
// during the sweep; configuration writes are taken at any time but must only
// be issued while the pipeline is empty. Addresses beyond the panel leave the
// store alone and are shaded as if their old level were zero.
module lcd_persistence_shader #(
  parameter int PANEL_WIDTH  = lcdps_pkg::PANEL_WIDTH_DEF,
  parameter int PANEL_HEIGHT = lcdps_pkg::PANEL_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lcdps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lcdps_pkg::CFG_DATA_W-1:0]  cfg_data,
  // pixel stream in
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lcdps_pkg::IN_TDATA_W-1:0]  in_tdata,   // [0] pixel_on, [13:1] pixel_address
  // shaded stream out
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lcdps_pkg::OUT_TDATA_W-1:0] out_tdata   // [12:0] out_address,
                                                        // [20:13] gray_level, [28:21] red_out,
                                                        // [36:29] green_out, [44:37] blue_out
);
  import lcdps_pkg::*;

  localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
  localparam int IDX_W = $clog2(DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [CONTRAST_W-1:0] contrast_r;
  logic                  blank_r;
  rgb16_t                back_r;
  rgb16_t                fore_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      contrast_r <= CONTRAST_RST;
      blank_r    <= 1'b0;
      back_r     <= '{red: BACK_RST, green: BACK_RST, blue: BACK_RST};
      fore_r     <= '{red: FORE_RST, green: FORE_RST, blue: FORE_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CONTRAST:   contrast_r   <= cfg_data[CONTRAST_W-1:0];
        CFG_BLANK:      blank_r      <= cfg_data[0];
        CFG_BACK_RED:   back_r.red   <= cfg_data;
        CFG_BACK_GREEN: back_r.green <= cfg_data;
        CFG_BACK_BLUE:  back_r.blue  <= cfg_data;
        CFG_FORE_RED:   fore_r.red   <= cfg_data;
        CFG_FORE_GREEN: fore_r.green <= cfg_data;
        CFG_FORE_BLUE:  fore_r.blue  <= cfg_data;
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic                  in_pixel_on;
  logic [ADDR_W-1:0]     in_addr;
  logic [ADDR_EXT_W-1:0] in_addr_ext;
  logic                  in_inside;
  logic [IDX_W-1:0]      in_idx;
  logic                  in_fire;
  logic                  store_busy;

  assign in_pixel_on = in_tdata[0];
  assign in_addr     = in_tdata[ADDR_W:1];
  assign in_addr_ext = {{(ADDR_EXT_W - ADDR_W){1'b0}}, in_addr};
  assign in_inside   = in_addr_ext < ADDR_EXT_W'(DEPTH);
  assign in_idx      = in_addr_ext[IDX_W-1:0];
  assign in_fire     = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // Stage 1: RAM data is back; compute the new level and write it back
  // ---------------------------------------------------------------------------
  logic               s1_valid_r;
  logic               s1_on_r;
  logic               s1_inside_r;
  logic [ADDR_W-1:0]  s1_addr_r;
  logic [IDX_W-1:0]   s1_idx_r;
  logic               fwd_hit_r;
  logic [LEVEL_W-1:0] fwd_level_r;
  logic [LEVEL_W-1:0] rd_level;
  logic [LEVEL_W-1:0] s1_old;
  logic [LEVEL_W-1:0] s1_level;
  logic               s1_adv;
  logic               s2_ready;

  // hold off new beats while stage 1 is stuck or the RAM is still clearing
  assign in_tready = !store_busy && (!s1_valid_r || s2_ready);
  assign s1_adv    = s1_valid_r && s2_ready;

  // the RAM read of a beat lands on the same edge as the write of the beat
  // ahead of it, so take that beat's level instead when the entry matches
  assign s1_old   = !s1_inside_r ? '0 : (fwd_hit_r ? fwd_level_r : rd_level);
  assign s1_level = next_level(s1_old, pick_target(contrast_r, blank_r, s1_on_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_on_r     <= in_pixel_on;
      s1_inside_r <= in_inside;
      s1_addr_r   <= in_addr;
      s1_idx_r    <= in_idx;
      fwd_hit_r   <= s1_valid_r && s1_inside_r && (s1_idx_r == in_idx);
      fwd_level_r <= s1_level;
    end
  end

  lcdps_level_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire),
    .rd_idx  (in_idx),
    .rd_data (rd_level),
    .wr_en   (s1_adv && s1_inside_r),
    .wr_idx  (s1_idx_r),
    .wr_data (s1_level),
    .busy    (store_busy)
  );

  // ---------------------------------------------------------------------------
  // Stage 2: level register feeding the color blend
  // ---------------------------------------------------------------------------
  logic               s2_valid_r;
  logic [ADDR_W-1:0]  s2_addr_r;
  logic [LEVEL_W-1:0] s2_level_r;
  logic               blend_ready;

  assign s2_ready = !s2_valid_r || blend_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_r <= 1'b1;
    end else if (blend_ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_addr_r  <= s1_addr_r;
      s2_level_r <= s1_level;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: blend and output register
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0]  out_addr;
  logic [LEVEL_W-1:0] out_level;
  rgb8_t              out_color;

  lcdps_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_ready  (blend_ready),
    .in_addr   (s2_addr_r),
    .in_level  (s2_level_r),
    .back      (back_r),
    .fore      (fore_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_addr  (out_addr),
    .out_level (out_level),
    .out_color (out_color)
  );

  assign out_tdata = {3'b000, out_color.blue, out_color.green, out_color.red,
                      out_level, out_addr};

endmodule
